@@ hw/rtl/lbwa_pkg.sv @@
package lbwa_pkg;

  localparam int DATA_W        = 16;
  localparam int BEAM_W        = 22;
  localparam int CFG_IDX_W     = 3;
  localparam int MAX_GROUP_DEF = 8;
  localparam int DIV_STEP_BITS = 5;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_FIRST = 3'd0,
    CFG_WINDOW_LAST  = 3'd1,
    CFG_EXCL_FIRST   = 3'd2,
    CFG_EXCL_LAST    = 3'd3,
    CFG_BLOCKS       = 3'd4,
    CFG_BEAMS        = 3'd5,
    CFG_GROUP        = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] win_first;
    logic signed [DATA_W-1:0] win_last;
    logic signed [DATA_W-1:0] excl_first;
    logic signed [DATA_W-1:0] excl_last;
    logic [7:0]               blocks_per_scan;
    logic [10:0]              beams_per_block;
  } front_cfg_t;

  typedef struct packed {
    logic              scan_start;
    logic              counted;
    logic [DATA_W-1:0] distance;
    logic [DATA_W-1:0] strength;
  } beam_entry_t;

  typedef struct packed {
    logic idle;
    logic done;
  } div_status_t;

endpackage

@@ hw/rtl/lbwa_front.sv @@
module lbwa_front import lbwa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  front_cfg_t        cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        block_number,
  input  logic [9:0]        beam_in_block,
  input  logic [DATA_W-1:0] raw_distance,
  input  logic [DATA_W-1:0] raw_strength,
  output logic              push,
  output beam_entry_t       push_entry,
  input  logic              q_full
);

  logic                     s_valid;
  logic signed [BEAM_W-1:0] prod;
  logic [9:0]               pos;
  logic [DATA_W-1:0]        distance;
  logic [DATA_W-1:0]        strength;

  logic signed [9:0]        diff;
  logic signed [11:0]       bpb_s;
  logic signed [BEAM_W-1:0] prod_next;
  logic signed [BEAM_W-1:0] beam;
  logic signed [BEAM_W-1:0] wf, wl, ef, el;
  logic                     drop;
  logic                     s_adv;

  // The block offset is taken against half a revolution, so early blocks map to
  // negative beam indexes.
  always_comb begin
    diff      = $signed({2'b00, block_number}) - $signed({3'b000, cfg.blocks_per_scan[7:1]});
    bpb_s     = $signed({1'b0, cfg.beams_per_block});
    prod_next = BEAM_W'(diff) * BEAM_W'(bpb_s);
  end

  always_comb begin
    beam = prod + $signed({{(BEAM_W-10){1'b0}}, pos});
    wf   = $signed({{(BEAM_W-DATA_W){cfg.win_first[DATA_W-1]}}, cfg.win_first});
    wl   = $signed({{(BEAM_W-DATA_W){cfg.win_last[DATA_W-1]}}, cfg.win_last});
    ef   = $signed({{(BEAM_W-DATA_W){cfg.excl_first[DATA_W-1]}}, cfg.excl_first});
    el   = $signed({{(BEAM_W-DATA_W){cfg.excl_last[DATA_W-1]}}, cfg.excl_last});
    drop = (beam < wf) || (beam > wl);
    push_entry.scan_start = (beam == wf);
    push_entry.counted    = !((beam >= ef) && (beam <= el));
    push_entry.distance   = distance;
    push_entry.strength   = strength;
  end

  assign s_adv    = s_valid && (drop || !q_full);
  assign push     = s_valid && !drop && !q_full;
  assign in_ready = !rst && (!s_valid || s_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      prod     <= prod_next;
      pos      <= beam_in_block;
      distance <= raw_distance;
      strength <= raw_strength;
    end
  end

endmodule

@@ hw/rtl/lbwa_queue.sv @@
module lbwa_queue import lbwa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  beam_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output beam_entry_t pop_entry
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  beam_entry_t      entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop) && !(full && !pop))
    else $error("item pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("item popped from an empty queue");

endmodule

@@ hw/rtl/lbwa_div.sv @@
module lbwa_div import lbwa_pkg::*; #(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 take,
  input  logic [DATA_W+$clog2(MAX_GROUP)-1:0]  dividend_a,
  input  logic [DATA_W+$clog2(MAX_GROUP)-1:0]  dividend_b,
  input  logic [$clog2(MAX_GROUP+1)-1:0]       divisor,
  output div_status_t                          status,
  output logic [DATA_W-1:0]                    quot_a,
  output logic [DATA_W-1:0]                    quot_b
);

  localparam int CNT_W  = $clog2(MAX_GROUP + 1);
  localparam int SUM_W  = DATA_W + $clog2(MAX_GROUP);
  localparam int STEPS  = (SUM_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PAD_W  = STEPS * DIV_STEP_BITS;
  localparam int STEP_W = $clog2(STEPS + 1);

  typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_DONE} div_state_t;

  div_state_t        state;
  logic [PAD_W-1:0]  dvd_a, dvd_b;
  logic [CNT_W-1:0]  rem_a, rem_b;
  logic [CNT_W-1:0]  dsr;
  logic [STEP_W-1:0] steps;

  logic [PAD_W-1:0]  a_next, b_next;
  logic [CNT_W-1:0]  ra_next, rb_next;
  logic [CNT_W:0]    trial_a, trial_b;

  // Restoring division, several quotient bits per cycle. The quotient bits
  // shift into the low end of the dividend register as it empties.
  always_comb begin
    a_next  = dvd_a;
    b_next  = dvd_b;
    ra_next = rem_a;
    rb_next = rem_b;
    trial_a = '0;
    trial_b = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial_a = {ra_next, a_next[PAD_W-1]};
      trial_b = {rb_next, b_next[PAD_W-1]};
      if (trial_a >= {1'b0, dsr}) begin
        ra_next = CNT_W'(trial_a - {1'b0, dsr});
        a_next  = {a_next[PAD_W-2:0], 1'b1};
      end else begin
        ra_next = trial_a[CNT_W-1:0];
        a_next  = {a_next[PAD_W-2:0], 1'b0};
      end
      if (trial_b >= {1'b0, dsr}) begin
        rb_next = CNT_W'(trial_b - {1'b0, dsr});
        b_next  = {b_next[PAD_W-2:0], 1'b1};
      end else begin
        rb_next = trial_b[CNT_W-1:0];
        b_next  = {b_next[PAD_W-2:0], 1'b0};
      end
    end
  end

  assign status.idle = (state == DIV_IDLE) || ((state == DIV_DONE) && take);
  assign status.done = (state == DIV_DONE);
  assign quot_a      = dvd_a[DATA_W-1:0];
  assign quot_b      = dvd_b[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      unique case (state)
        DIV_IDLE: begin
          if (start) begin
            state <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          if (steps == STEP_W'(1)) begin
            state <= DIV_DONE;
          end
        end
        DIV_DONE: begin
          if (take) begin
            state <= start ? DIV_RUN : DIV_IDLE;
          end
        end
        default: state <= DIV_IDLE;
      endcase
    end
    if (start && status.idle) begin
      dvd_a <= PAD_W'(dividend_a);
      dvd_b <= PAD_W'(dividend_b);
      rem_a <= '0;
      rem_b <= '0;
      dsr   <= divisor;
      steps <= STEP_W'(STEPS);
    end else if (state == DIV_RUN) begin
      dvd_a <= a_next;
      dvd_b <= b_next;
      rem_a <= ra_next;
      rem_b <= rb_next;
      steps <= steps - 1'b1;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && status.idle) |-> ##(STEPS + 1) status.done)
    else $error("division did not finish in the expected number of cycles");

endmodule

@@ hw/rtl/lbwa_back.sv @@
module lbwa_back import lbwa_pkg::*; #(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [3:0]        group_size,
  input  logic              q_valid,
  input  beam_entry_t       q_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] slot_index,
  output logic [DATA_W-1:0] mean_distance,
  output logic              no_return,
  output logic [DATA_W-1:0] mean_strength
);

  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int SUM_W = DATA_W + $clog2(MAX_GROUP);

  logic [SUM_W-1:0]  dsum, ssum;
  logic [CNT_W-1:0]  cnt, slot;
  logic [DATA_W-1:0] gcount;
  logic              saw_nr;

  logic [DATA_W-1:0] hold_slot;
  logic              hold_nr;
  logic              hold_zero;

  logic [CNT_W-1:0]  gs_eff;
  logic [SUM_W-1:0]  dsum_next, ssum_next;
  logic [CNT_W-1:0]  cnt_next, slot_next;
  logic [DATA_W-1:0] gcount_base;
  logic              saw_nr_next;
  logic              close;
  logic              div_start;
  logic              take;
  div_status_t       div_st;
  logic [DATA_W-1:0] quot_a, quot_b;

  always_comb begin
    if (group_size == '0) begin
      gs_eff = CNT_W'(1);
    end else if (int'(group_size) > MAX_GROUP) begin
      gs_eff = CNT_W'(MAX_GROUP);
    end else begin
      gs_eff = CNT_W'(group_size);
    end
  end

  // A scan start drops whatever partial group was pending and restarts slot
  // numbering before the item itself is added.
  always_comb begin
    if (q_entry.scan_start) begin
      dsum_next   = '0;
      ssum_next   = '0;
      cnt_next    = '0;
      slot_next   = '0;
      gcount_base = '0;
      saw_nr_next = 1'b0;
    end else begin
      dsum_next   = dsum;
      ssum_next   = ssum;
      cnt_next    = cnt;
      slot_next   = slot;
      gcount_base = gcount;
      saw_nr_next = saw_nr;
    end
    if (q_entry.counted) begin
      cnt_next = cnt_next + 1'b1;
      if (q_entry.distance != '0) begin
        dsum_next = dsum_next + SUM_W'(q_entry.distance);
        ssum_next = ssum_next + SUM_W'(q_entry.strength);
      end else begin
        saw_nr_next = 1'b1;
      end
    end
    slot_next = slot_next + 1'b1;
    close     = (slot_next >= gs_eff);
  end

  assign pop       = q_valid && (!close || div_st.idle);
  assign div_start = pop && close;
  assign take      = div_st.done && (!out_valid || out_ready);

  lbwa_div #(.MAX_GROUP(MAX_GROUP)) u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .take       (take),
    .dividend_a (dsum_next),
    .dividend_b (ssum_next),
    .divisor    (cnt_next),
    .status     (div_st),
    .quot_a     (quot_a),
    .quot_b     (quot_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dsum      <= '0;
      ssum      <= '0;
      cnt       <= '0;
      slot      <= '0;
      gcount    <= '0;
      saw_nr    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (close) begin
          dsum   <= '0;
          ssum   <= '0;
          cnt    <= '0;
          slot   <= '0;
          saw_nr <= 1'b0;
          gcount <= gcount_base + 1'b1;
        end else begin
          dsum   <= dsum_next;
          ssum   <= ssum_next;
          cnt    <= cnt_next;
          slot   <= slot_next;
          saw_nr <= saw_nr_next;
          gcount <= gcount_base;
        end
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (div_start) begin
      hold_slot <= gcount_base;
      hold_nr   <= saw_nr_next;
      hold_zero <= (cnt_next == '0);
    end
    if (take) begin
      slot_index    <= hold_slot;
      no_return     <= hold_nr;
      mean_distance <= (hold_zero || hold_nr) ? '0 : quot_a;
      mean_strength <= hold_zero ? '0 : quot_b;
    end
  end

  a_result_moves: assert property (@(posedge clk) disable iff (rst)
    (div_st.done && !(out_valid && !out_ready)) |=> out_valid)
    else $error("finished group did not reach the output register");

  a_close_needs_divider: assert property (@(posedge clk) disable iff (rst)
    (q_valid && close && !div_st.idle) |-> !pop)
    else $error("group closed while the divider was busy");

endmodule

@@ hw/rtl/lidar_beam_window_average.sv @@
// Lidar beam window averager. Beam samples enter one per cycle while in_ready
// is high; each gets a signed beam index, samples outside the window are
// dropped, samples in the excluded band keep their slot but add nothing, and
// every group_size kept slots give one result with the truncated mean range
// and intensity (range forced to zero and no_return set when any counted
// sample had no return). A sample at the first window beam restarts the scan
// and drops a partial group. Structure: the classifying front feeds a
// two-entry queue; the accumulator takes one queued item per cycle unless the
// item closes a group while the shared divider is busy. Items of the next
// group keep accumulating while the divider works, but a group cannot close
// until the divider has handed its last result to the output register.
// The user must write configuration through the cfg port only while no item
// is in flight; the block itself does not enforce this.
module lidar_beam_window_average import lbwa_pkg::*; #(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           block_number,
  input  logic [9:0]           beam_in_block,
  input  logic [DATA_W-1:0]    raw_distance,
  input  logic [DATA_W-1:0]    raw_strength,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    slot_index,
  output logic [DATA_W-1:0]    mean_distance,
  output logic                 no_return,
  output logic [DATA_W-1:0]    mean_strength
);

  front_cfg_t  fcfg;
  logic [3:0]  group_size;

  logic        push;
  beam_entry_t push_entry;
  logic        q_full;
  logic        pop;
  logic        q_valid;
  beam_entry_t q_entry;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcfg.win_first       <= 16'sd0;
      fcfg.win_last        <= 16'sd0;
      fcfg.excl_first      <= 16'sd1;
      fcfg.excl_last       <= 16'sd0;
      fcfg.blocks_per_scan <= 8'd1;
      fcfg.beams_per_block <= 11'd1;
      group_size           <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW_FIRST: fcfg.win_first       <= $signed(cfg_data);
        CFG_WINDOW_LAST:  fcfg.win_last        <= $signed(cfg_data);
        CFG_EXCL_FIRST:   fcfg.excl_first      <= $signed(cfg_data);
        CFG_EXCL_LAST:    fcfg.excl_last       <= $signed(cfg_data);
        CFG_BLOCKS:       fcfg.blocks_per_scan <= cfg_data[7:0];
        CFG_BEAMS:        fcfg.beams_per_block <= cfg_data[10:0];
        CFG_GROUP:        group_size           <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  lbwa_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (fcfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .block_number  (block_number),
    .beam_in_block (beam_in_block),
    .raw_distance  (raw_distance),
    .raw_strength  (raw_strength),
    .push          (push),
    .push_entry    (push_entry),
    .q_full        (q_full)
  );

  lbwa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_valid),
    .pop_entry  (q_entry)
  );

  lbwa_back #(.MAX_GROUP(MAX_GROUP)) u_back (
    .clk           (clk),
    .rst           (rst),
    .group_size    (group_size),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .slot_index    (slot_index),
    .mean_distance (mean_distance),
    .no_return     (no_return),
    .mean_strength (mean_strength)
  );

endmodule
